// ===== sv/imsw_pkg.sv =====
// Shared types and constants for the interval mean and standard deviation block.
`timescale 1ns / 1ps
`default_nettype none
package imsw_pkg;

  localparam int MaxSamples = 1048576;
  localparam int CntW       = 21;
  localparam int FifoDepth  = 2;
  localparam int FifoPtrW   = 1;
  localparam int FifoCntW   = 2;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [62:0] value;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic [62:0]     welford_mean;
    logic [31:0]     std_dev;
    logic [62:0]     sum_average;
    logic [CntW-1:0] sample_count;
    logic            order_error;
    logic            empty_set;
  } out_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [62:0] sample;
    logic        last;
  } op_t;

endpackage
`default_nettype wire

// ===== sv/imsw_front.sv =====
// Front end: config register, period extraction and sample classification.
`timescale 1ns / 1ps
`default_nettype none
module imsw_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire imsw_pkg::in_word_t in_word_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output imsw_pkg::op_t           q_op_o
);

  logic        diff_q, diff_d;
  logic [62:0] prev_q, prev_d;
  logic        have_q, have_d;
  logic [63:0] period;
  logic        acc;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i & ~q_full_i;
  assign q_push_o   = acc;
  assign period     = {1'b0, in_word_i.value} - {1'b0, prev_q};

  always_comb begin
    q_op_o.last   = in_word_i.last;
    q_op_o.sample = in_word_i.value;
    q_op_o.kind   = imsw_pkg::KIND_SAMPLE;
    if (diff_q) begin
      q_op_o.sample = period[62:0];
      if (!have_q) begin
        q_op_o.kind = imsw_pkg::KIND_NONE;
      end else if (period[63]) begin
        q_op_o.kind = imsw_pkg::KIND_ERROR;
      end
    end
  end

  always_comb begin
    diff_d = cfg_we_i ? cfg_wdata_i : diff_q;
    prev_d = prev_q;
    have_d = have_q;
    if (acc) begin
      // drop the history at the end of a set
      prev_d = in_word_i.last ? 63'd0 : in_word_i.value;
      have_d = ~in_word_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= 1'b1;
      prev_q <= '0;
      have_q <= 1'b0;
    end else begin
      diff_q <= diff_d;
      prev_q <= prev_d;
      have_q <= have_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/imsw_fifo.sv =====
// Two-entry queue of classified operations between front and back.
`timescale 1ns / 1ps
`default_nettype none
module imsw_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire imsw_pkg::op_t op_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output imsw_pkg::op_t      op_o
);

  imsw_pkg::op_t                    mem_q [imsw_pkg::FifoDepth];
  logic [imsw_pkg::FifoPtrW-1:0]    wp_q, rp_q;
  logic [imsw_pkg::FifoCntW-1:0]    cnt_q;

  function automatic logic [imsw_pkg::FifoCntW-1:0] FifoCntW_inc(input logic b);
    FifoCntW_inc = {{(imsw_pkg::FifoCntW-1){1'b0}}, b};
  endfunction

  assign full_o  = (cnt_q == imsw_pkg::FifoCntW'(imsw_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + FifoCntW_inc(push_i) - FifoCntW_inc(pop_i);
    end
  end

endmodule
`default_nettype wire

// ===== sv/imsw_div.sv =====
// Restoring divider: 64-bit dividend by count, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module imsw_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [63:0]               dividend_i,
  input  wire logic [imsw_pkg::CntW-1:0] divisor_i,
  output logic                           done_o,
  output logic [63:0]                    quot_o
);

  logic [63:0]               q_q;
  logic [imsw_pkg::CntW-1:0] rem_q, dvs_q;
  logic [imsw_pkg::CntW:0]   rem_sh;
  logic                      ge;
  logic                      busy_q, done_q;
  logic [5:0]                step_q;

  assign rem_sh = {rem_q, q_q[63]};
  assign ge     = (rem_sh >= {1'b0, dvs_q});
  assign done_o = done_q;
  assign quot_o = q_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? imsw_pkg::CntW'(rem_sh - {1'b0, dvs_q}) : rem_sh[imsw_pkg::CntW-1:0];
      q_q   <= {q_q[62:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/imsw_back.sv =====
// Back end: Welford update, saturating sums and end-of-set statistics.
`timescale 1ns / 1ps
`default_nettype none
module imsw_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire imsw_pkg::op_t q_op_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output imsw_pkg::out_word_t out_word_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DELTA = 4'd1;
  localparam logic [3:0] S_DIVGO = 4'd2;
  localparam logic [3:0] S_MDIV  = 4'd3;
  localparam logic [3:0] S_REST  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_D1    = 4'd8;
  localparam logic [3:0] S_D2GO  = 4'd9;
  localparam logic [3:0] S_D2    = 4'd10;
  localparam logic [3:0] S_SQ    = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]                st_q, st_d;
  logic [imsw_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [62:0]               mean_q, mean_d, x_q, x_d;
  logic [63:0]               m2_q, m2_d, sum_q, sum_d;
  logic                      err_q, err_d, last_q, last_d, neg_q, neg_d;
  logic [62:0]               magd_q, magd_d, magr_q, magr_d;
  logic [127:0]              acc_q, acc_d;
  logic [1:0]                mstep_q, mstep_d;
  logic [63:0]               m2div_q, m2div_d, avg_q, avg_d;
  logic [63:0]               sqn_q, sqn_d, root_q, root_d, bit_q, bit_d;
  logic [4:0]                sqc_q, sqc_d;
  imsw_pkg::out_word_t       out_q, out_d;
  logic                      ov_q, ov_d;

  logic                      div_start, div_done;
  logic [63:0]               div_dvd, div_quot;
  logic [63:0]               diff, mag, prod, prodsat, rb, shp;
  logic [31:0]               pa, pb;
  logic [64:0]               m2sum, sumsum;
  logic [127:0]              psh;
  logic                      load;

  imsw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign diff    = {1'b0, x_q} - {1'b0, mean_q};
  assign mag     = diff[63] ? (64'd0 - diff) : diff;
  assign pa      = mstep_q[1] ? {1'b0, magd_q[62:32]} : magd_q[31:0];
  assign pb      = mstep_q[0] ? {1'b0, magr_q[62:32]} : magr_q[31:0];
  assign prod    = pa * pb;
  assign shp     = prod;
  assign psh     = (mstep_q == 2'd0) ? {64'd0, shp} :
                   (mstep_q == 2'd3) ? {shp, 64'd0} : {32'd0, shp, 32'd0};
  assign prodsat = (|acc_q[127:64]) ? '1 : acc_q[63:0];
  assign m2sum   = {1'b0, m2_q} + {1'b0, prodsat};
  assign sumsum  = {1'b0, sum_q} + {2'b0, x_q};
  assign rb      = root_q + bit_q;
  assign load    = (st_q == S_OUT) && (!ov_q || !out_stall_i);

  assign out_valid_o = ov_q;
  assign out_word_o  = out_q;

  always_comb begin
    st_d = st_q;  cnt_d = cnt_q;  mean_d = mean_q;  x_d = x_q;
    m2_d = m2_q;  sum_d = sum_q;  err_d = err_q;   last_d = last_q;
    neg_d = neg_q;  magd_d = magd_q;  magr_d = magr_q;
    acc_d = acc_q;  mstep_d = mstep_q;  m2div_d = m2div_q;  avg_d = avg_q;
    sqn_d = sqn_q;  root_d = root_q;  bit_d = bit_q;  sqc_d = sqc_q;
    out_d = out_q;
    ov_d = ov_q & out_stall_i;
    q_pop_o = 1'b0;
    div_start = 1'b0;
    div_dvd = {1'b0, magd_q};
    unique case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          x_d     = q_op_i.sample;
          last_d  = q_op_i.last;
          if (q_op_i.kind == imsw_pkg::KIND_SAMPLE &&
              cnt_q < imsw_pkg::CntW'(imsw_pkg::MaxSamples)) begin
            cnt_d = cnt_q + 1'b1;
            st_d  = S_DELTA;
          end else begin
            if (q_op_i.kind == imsw_pkg::KIND_ERROR) begin
              err_d = 1'b1;
            end
            st_d = q_op_i.last ? S_FIN : S_IDLE;
          end
        end
      end
      S_DELTA: begin
        neg_d  = diff[63];
        magd_d = mag[62:0];
        st_d   = S_DIVGO;
      end
      S_DIVGO: begin
        div_start = 1'b1;
        st_d      = S_MDIV;
      end
      S_MDIV: begin
        if (div_done) begin
          mean_d = neg_q ? (mean_q - div_quot[62:0]) : (mean_q + div_quot[62:0]);
          st_d   = S_REST;
        end
      end
      S_REST: begin
        magr_d  = mag[62:0];
        acc_d   = '0;
        mstep_d = 2'd0;
        st_d    = S_MUL;
      end
      S_MUL: begin
        // accumulate four 32x32 partial products
        acc_d   = acc_q + psh;
        mstep_d = mstep_q + 1'b1;
        if (mstep_q == 2'd3) begin
          st_d = S_ACC;
        end
      end
      S_ACC: begin
        m2_d  = m2sum[64] ? '1 : m2sum[63:0];
        sum_d = sumsum[64] ? '1 : sumsum[63:0];
        st_d  = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (cnt_q == '0) begin
          st_d = S_OUT;
        end else begin
          div_start = 1'b1;
          div_dvd   = m2_q;
          st_d      = S_D1;
        end
      end
      S_D1: begin
        if (div_done) begin
          m2div_d = div_quot;
          st_d    = S_D2GO;
        end
      end
      S_D2GO: begin
        div_start = 1'b1;
        div_dvd   = sum_q;
        st_d      = S_D2;
      end
      S_D2: begin
        if (div_done) begin
          avg_d  = div_quot;
          sqn_d  = m2div_q;
          root_d = '0;
          bit_d  = 64'd1 << 62;
          sqc_d  = '0;
          st_d   = S_SQ;
        end
      end
      S_SQ: begin
        if (sqn_q >= rb) begin
          sqn_d  = sqn_q - rb;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        sqc_d = sqc_q + 1'b1;
        if (sqc_q == 5'd31) begin
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (load) begin
          ov_d = 1'b1;
          out_d.sample_count = cnt_q;
          out_d.order_error  = err_q;
          out_d.empty_set    = (cnt_q == '0);
          if (cnt_q == '0) begin
            out_d.welford_mean = '0;
            out_d.std_dev      = '0;
            out_d.sum_average  = '0;
          end else begin
            out_d.welford_mean = mean_q;
            out_d.std_dev      = root_q[31:0];
            out_d.sum_average  = avg_q[62:0];
          end
          // clear the set for the next one
          cnt_d  = '0;
          mean_d = '0;
          m2_d   = '0;
          sum_d  = '0;
          err_d  = 1'b0;
          st_d   = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;  last_q <= last_d;  neg_q <= neg_d;  magd_q <= magd_d;
    magr_q <= magr_d;  acc_q <= acc_d;  mstep_q <= mstep_d;
    m2div_q <= m2div_d;  avg_q <= avg_d;  sqn_q <= sqn_d;  root_q <= root_d;
    bit_q <= bit_d;  sqc_q <= sqc_d;  out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      mean_q <= '0;
      m2_q   <= '0;
      sum_q  <= '0;
      err_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      mean_q <= mean_d;
      m2_q   <= m2_d;
      sum_q  <= sum_d;
      err_q  <= err_d;
      ov_q   <= ov_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= imsw_pkg::CntW'(imsw_pkg::MaxSamples))
    else $error("sample count beyond limit");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_q.empty_set |-> out_q.sample_count == '0)
    else $error("empty set reports samples");
  a_idle_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> st_q == S_IDLE && cnt_q == '0 && !err_q)
    else $error("set not cleared after result");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> st_q == S_IDLE)
    else $error("queue popped while busy");
`endif

endmodule
`default_nettype wire

// ===== sv/interval_mean_stddev_welford.sv =====
// Top level: streaming interval statistics with an online Welford variance.
//
// Input words carry a 63-bit value and a last marker over valid/stall. With
// take_differences set (its reset value) each value after the first of a set
// gives a period sample; a negative period flags order_error and is skipped.
// With it clear each value is a sample. One result word leaves on each last
// item, over valid/stall, and the set state is cleared after it.
// A front end classifies words and pushes them into a two-entry queue; it
// stalls only while that queue is full. The back end takes one entry at a
// time: a sample waits on the shared bit-serial divider for its mean update
// and then on the partial-product multiplier. A last item of a non-empty set
// adds two divisions by the count and a 32-step square root, then a load
// into the output register. A skipped or non-sample item does no arithmetic.
// A stalled result holds in the output register; the back end then waits
// and the queue fills, after which the input stalls. Reset clears all set
// state and the queue, and sets take_differences to 1. Write the
// configuration only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module interval_mean_stddev_welford (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire imsw_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output imsw_pkg::out_word_t      out_word_o
);

  imsw_pkg::op_t push_op, pop_op;
  logic          push, pop, full, qvalid;

  imsw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_op_o      (push_op)
  );

  imsw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .op_o    (pop_op)
  );

  imsw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (qvalid),
    .q_op_i      (pop_op),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_interval_mean_stddev_welford.sv =====
// Testbench for the interval statistics block: directed and random stimulus checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_interval_mean_stddev_welford;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 400;

  // Predicts the statistics of each set and checks the result words.
  class interval_stats_board;
    bit          diff_mode;
    logic [62:0] prev_value;
    bit          have_prev;
    int unsigned n_taken;
    longint      mean_acc;
    logic [63:0] m2_acc;
    logic [63:0] sum_acc;
    bit          order_bad;
    imsw_pkg::out_word_t pending_stats[$];
    int          failures;

    function new();
      diff_mode = 1'b1;
      failures  = 0;
      clear_set();
    endfunction

    function void clear_set();
      prev_value   = '0;
      have_prev    = 1'b0;
      n_taken      = 0;
      mean_acc     = 0;
      m2_acc       = '0;
      sum_acc      = '0;
      order_bad    = 1'b0;
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n    = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function void take_sample(logic [63:0] x);
      longint      delta;
      longint      rest;
      logic [63:0] mag_d;
      logic [63:0] mag_r;
      logic [127:0] prod;
      logic [64:0] s;
      if (n_taken >= imsw_pkg::MaxSamples) return;
      n_taken++;
      delta    = longint'(x) - mean_acc;
      mean_acc = mean_acc + delta / longint'(n_taken);
      rest     = longint'(x) - mean_acc;
      mag_d    = (delta < 0) ? -delta : delta;
      mag_r    = (rest < 0) ? -rest : rest;
      prod     = mag_d * mag_r;
      if (prod[127:64] != 0) prod[63:0] = '1;
      s      = {1'b0, m2_acc} + {1'b0, prod[63:0]};
      m2_acc = s[64] ? '1 : s[63:0];
      s       = {1'b0, sum_acc} + {1'b0, x};
      sum_acc = s[64] ? '1 : s[63:0];
    endfunction

    function void note_input(imsw_pkg::in_word_t w);
      imsw_pkg::out_word_t r;
      logic [63:0] q;
      if (diff_mode) begin
        if (have_prev) begin
          if (w.value < prev_value) order_bad = 1'b1;
          else take_sample({1'b0, w.value - prev_value});
        end
      end else begin
        take_sample({1'b0, w.value});
      end
      prev_value = w.value;
      have_prev  = 1'b1;
      if (!w.last) return;
      r = '0;
      if (n_taken == 0) begin
        r.empty_set = 1'b1;
      end else begin
        r.welford_mean = mean_acc[62:0];
        q              = floor_sqrt(m2_acc / 64'(n_taken));
        r.std_dev      = q[31:0];
        q              = sum_acc / 64'(n_taken);
        r.sum_average  = q[62:0];
      end
      r.sample_count = n_taken[imsw_pkg::CntW-1:0];
      r.order_error  = order_bad;
      pending_stats.push_back(r);
      clear_set();
    endfunction

    function void check_result(imsw_pkg::out_word_t got);
      imsw_pkg::out_word_t e;
      if (pending_stats.size() == 0) begin
        $error("unexpected result word %h", got);
        failures++;
        return;
      end
      e = pending_stats.pop_front();
      if (got.welford_mean !== e.welford_mean) begin
        $error("welford_mean exp %0d got %0d", e.welford_mean, got.welford_mean);
        failures++;
      end
      if (got.std_dev !== e.std_dev) begin
        $error("std_dev exp %0d got %0d", e.std_dev, got.std_dev);
        failures++;
      end
      if (got.sum_average !== e.sum_average) begin
        $error("sum_average exp %0d got %0d", e.sum_average, got.sum_average);
        failures++;
      end
      if (got.sample_count !== e.sample_count) begin
        $error("sample_count exp %0d got %0d", e.sample_count, got.sample_count);
        failures++;
      end
      if (got.order_error !== e.order_error) begin
        $error("order_error exp %0d got %0d", e.order_error, got.order_error);
        failures++;
      end
      if (got.empty_set !== e.empty_set) begin
        $error("empty_set exp %0d got %0d", e.empty_set, got.empty_set);
        failures++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  imsw_pkg::in_word_t  in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  imsw_pkg::out_word_t out_word_o;

  interval_stats_board board;
  int idle_cycles;
  bit stall_enable;

  interval_mean_stddev_welford uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Check results and track progress at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(out_word_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stall pattern: long runs of either state, sometimes none at all.
  always @(negedge clk_i) begin
    if (!stall_enable) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 15) == 0) out_stall_i <= ~out_stall_i;
  end

  task automatic send_word(logic [62:0] value, bit last);
    imsw_pkg::in_word_t w;
    w.value = value;
    w.last  = last;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(w);
    @(negedge clk_i);
    // Hold valid into the next word inside a burst; drop it on a gap.
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic set_mode(bit diff);
    in_valid_i <= 1'b0;
    while (board.pending_stats.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= diff;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.diff_mode = diff;
  endtask

  function automatic logic [62:0] rand_value(int kind);
    logic [62:0] v;
    v = 63'({$urandom, $urandom});
    case (kind)
      0: return 63'($urandom_range(0, 1000));
      1: return v;
      2: return {1'b1, v[61:0]};
      default: return v >> $urandom_range(0, 62);
    endcase
  endfunction

  task automatic random_set(int len);
    logic [62:0] t;
    logic [62:0] step;
    int kind;
    kind = $urandom_range(0, 3);
    t    = rand_value(kind) >> 1;
    step = rand_value(kind) >> $urandom_range(4, 40);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(rand_value($urandom_range(0, 3)), i == len - 1);
      else begin
        t = t + step + 63'($urandom_range(0, 50));
        send_word(t, i == len - 1);
      end
    end
  endtask

  initial begin
    int sent;
    board        = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    out_stall_i  = 1'b0;
    stall_enable = 1'b0;
    idle_cycles  = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty sets, single items, extremes, negative period.
    send_word('0, 1'b1);
    send_word('1, 1'b1);
    send_word(63'd100, 1'b0);
    send_word(63'd50, 1'b0);
    send_word(63'd80, 1'b1);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word('1, 1'b1);
    set_mode(1'b0);
    send_word('1, 1'b0);
    send_word('1, 1'b0);
    send_word('1, 1'b0);
    send_word('0, 1'b1);
    send_word(63'd7, 1'b1);
    send_word(63'd1, 1'b0);
    send_word(63'd2, 1'b0);
    send_word(63'h2AAA_AAAA_AAAA_AAAA, 1'b0);
    send_word(63'h5555_5555_5555_5555, 1'b1);
    set_mode(1'b1);
    send_word('1, 1'b0);
    send_word('0, 1'b1);

    stall_enable = 1'b1;
    sent = 0;
    while (sent < 1850) begin
      int len;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 24);
      random_set(len);
      sent += len;
      if ($urandom_range(0, 19) == 0) set_mode($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) stall_enable = ~stall_enable;
    end
    set_mode(1'b1);

    in_valid_i   <= 1'b0;
    stall_enable = 1'b0;
    while (board.pending_stats.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (board.failures == 0 && board.pending_stats.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
